// ===== hdl/dual_stepper_command_sequencer_defines.svh =====
// Assertion macros shared by the checker of the dual stepper command sequencer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DUAL_STEPPER_COMMAND_SEQUENCER_DEFINES_SVH
`define DUAL_STEPPER_COMMAND_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DSCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define DSCS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dscs_pkg.sv =====
// Types, command codes and coil patterns of the dual stepper command sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package dscs_pkg;

    localparam int unsigned PERIOD_W = 12;

    typedef logic [1:0]          t_kind;
    typedef logic [7:0]          t_byte;
    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [1:0]          t_phase;
    typedef logic [3:0]          t_coils;

    localparam t_kind KIND_TICK   = 2'd0;
    localparam t_kind KIND_BYTE   = 2'd1;
    localparam t_kind KIND_BUTTON = 2'd2;

    localparam t_byte CMD_TOGGLE = 8'h71;   // q
    localparam t_byte CMD_FWD    = 8'h77;   // w
    localparam t_byte CMD_BACK   = 8'h73;   // s
    localparam t_byte CMD_LEFT   = 8'h61;   // a
    localparam t_byte CMD_RIGHT  = 8'h64;   // d
    localparam t_byte CMD_FAST   = 8'h66;   // f
    localparam t_byte CMD_SLOW   = 8'h67;   // g

    localparam logic CFG_SLOW = 1'b0;
    localparam logic CFG_FAST = 1'b1;

    localparam t_period SLOW_RESET = 12'd50;
    localparam t_period FAST_RESET = 12'd20;

    localparam t_coils COILS_OFF = 4'hF;
    localparam t_coils PAT0      = 4'h3;
    localparam t_coils PAT1      = 4'h6;
    localparam t_coils PAT2      = 4'hC;
    localparam t_coils PAT3      = 4'h9;

    typedef struct packed {
        logic enabled;
        logic fwd_first;
        logic fwd_second;
        logic slow;
    } t_ctrl;

    // mirrored order walks the table backwards: 3,9,C,6
    function automatic t_coils coil_pattern(input t_phase phase, input logic mirror);
        t_phase idx;
        t_coils pat;
        idx = mirror ? (2'd0 - phase) : phase;
        unique case (idx)
            2'd0:    pat = PAT0;
            2'd1:    pat = PAT1;
            2'd2:    pat = PAT2;
            default: pat = PAT3;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dscs_ctrl.sv =====
// Command decoder: enable, per-motor direction and speed mode state.
// Depends on dscs_pkg.
`default_nettype none

module dscs_ctrl
    import dscs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_kind i_command,
    input  wire t_byte i_command_byte,
    output t_ctrl      o_ctrl_next
);

    t_ctrl r_ctrl;
    t_ctrl n_ctrl;

    always_comb begin
        n_ctrl = r_ctrl;
        priority if (i_command == KIND_BUTTON) begin
            n_ctrl.enabled = ~r_ctrl.enabled;
        end else if (i_command == KIND_BYTE) begin
            unique case (i_command_byte)
                CMD_TOGGLE: n_ctrl.enabled = ~r_ctrl.enabled;
                CMD_FWD: begin
                    n_ctrl.fwd_first  = 1'b1;
                    n_ctrl.fwd_second = 1'b1;
                end
                CMD_BACK: begin
                    n_ctrl.fwd_first  = 1'b0;
                    n_ctrl.fwd_second = 1'b0;
                end
                CMD_LEFT: begin
                    n_ctrl.fwd_first  = 1'b0;
                    n_ctrl.fwd_second = 1'b1;
                end
                CMD_RIGHT: begin
                    n_ctrl.fwd_first  = 1'b1;
                    n_ctrl.fwd_second = 1'b0;
                end
                CMD_FAST: n_ctrl.slow = 1'b0;
                CMD_SLOW: n_ctrl.slow = 1'b1;
                default:  n_ctrl = r_ctrl;
            endcase
        end else begin
            n_ctrl = r_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '{enabled: 1'b1, fwd_first: 1'b1, fwd_second: 1'b1, slow: 1'b1};
        end else if (i_load) begin
            r_ctrl <= n_ctrl;
        end
    end

    assign o_ctrl_next = n_ctrl;

endmodule

`default_nettype wire

// ===== hdl/dscs_motor.sv =====
// One motor channel: step down-counter, phase and latched coil drive.
// Depends on dscs_pkg.
`default_nettype none

module dscs_motor
    import dscs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire logic    i_tick,
    input  wire logic    i_enabled,
    input  wire logic    i_forward,
    input  wire logic    i_mirror,
    input  wire t_period i_period,
    output t_coils       o_drive_next,
    output logic         o_stepped
);

    t_phase  r_phase;
    t_period r_count;
    t_coils  r_drive;
    t_phase  n_phase;
    t_period n_count;
    t_coils  n_drive;
    t_period count_dec;
    logic    step;

    always_comb begin
        count_dec = (i_tick && (r_count != '0)) ? (r_count - t_period'(1)) : r_count;
        step      = i_enabled && (count_dec == '0);
        n_phase   = r_phase;
        n_count   = count_dec;
        n_drive   = r_drive;
        if (step) begin
            n_phase = i_forward ? (r_phase + 2'd1) : (r_phase - 2'd1);
            n_count = i_period;
            n_drive = coil_pattern(r_phase, i_mirror);
        end
        if (!i_enabled) begin
            n_drive = COILS_OFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_count <= '0;
            r_drive <= COILS_OFF;
        end else if (i_load) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_drive <= n_drive;
        end
    end

    assign o_drive_next = n_drive;
    assign o_stepped    = step;

endmodule

`default_nettype wire

// ===== hdl/dual_stepper_command_sequencer.sv =====
// Dual full-step stepper sequencer driven by ticks, command bytes and button presses.
// Depends on dscs_pkg, dscs_ctrl and dscs_motor.
// Takes one item per clock cycle. Each accepted item updates the command state and both
// motor channels in the same cycle, and its result appears in the output register on the
// next cycle. The input side stalls only while a finished result waits unclaimed in that
// register; taking it frees the slot in the same cycle. Period registers are written
// through the plain write port (index 0 slow period, index 1 fast period) and reset to
// 50 and 20 ticks.
`default_nettype none

module dual_stepper_command_sequencer
    import dscs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [11:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_command_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_coils_first,
    output logic [3:0]       o_coils_second,
    output logic             o_motors_enabled,
    output logic             o_stepped_first,
    output logic             o_stepped_second
);

    t_period r_slow_period;
    t_period r_fast_period;
    logic    r_out_valid;
    t_coils  r_coils_first;
    t_coils  r_coils_second;
    logic    r_enabled;
    logic    r_stepped_first;
    logic    r_stepped_second;

    logic    accept;
    t_ctrl   ctrl_next;
    t_period period;
    t_coils  drive_first;
    t_coils  drive_second;
    logic    step_first;
    logic    step_second;
    logic    tick;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign tick       = (i_command == KIND_TICK);
    assign period     = ctrl_next.slow ? r_slow_period : r_fast_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_period <= SLOW_RESET;
            r_fast_period <= FAST_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SLOW) begin
                r_slow_period <= i_cfg_data;
            end else begin
                r_fast_period <= i_cfg_data;
            end
        end
    end

    dscs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_command      (i_command),
        .i_command_byte (i_command_byte),
        .o_ctrl_next    (ctrl_next)
    );

    dscs_motor u_motor_first (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_tick       (tick),
        .i_enabled    (ctrl_next.enabled),
        .i_forward    (ctrl_next.fwd_first),
        .i_mirror     (1'b0),
        .i_period     (period),
        .o_drive_next (drive_first),
        .o_stepped    (step_first)
    );

    dscs_motor u_motor_second (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_tick       (tick),
        .i_enabled    (ctrl_next.enabled),
        .i_forward    (ctrl_next.fwd_second),
        .i_mirror     (1'b1),
        .i_period     (period),
        .o_drive_next (drive_second),
        .o_stepped    (step_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coils_first    <= drive_first;
            r_coils_second   <= drive_second;
            r_enabled        <= ctrl_next.enabled;
            r_stepped_first  <= step_first;
            r_stepped_second <= step_second;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_coils_first    = r_coils_first;
    assign o_coils_second   = r_coils_second;
    assign o_motors_enabled = r_enabled;
    assign o_stepped_first  = r_stepped_first;
    assign o_stepped_second = r_stepped_second;

endmodule

`default_nettype wire

// ===== hdl/dscs_checker.sv =====
// Port-level checker for the dual stepper command sequencer, bound to the top level.
// Depends on dscs_pkg and dual_stepper_command_sequencer_defines.svh.
`default_nettype none

`include "dual_stepper_command_sequencer_defines.svh"

module dscs_checker
    import dscs_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [3:0] o_coils_first,
    input wire logic [3:0] o_coils_second,
    input wire logic       o_motors_enabled,
    input wire logic       o_stepped_first,
    input wire logic       o_stepped_second
);

    logic first_is_pat;
    logic second_is_pat;

    assign first_is_pat  = (o_coils_first == PAT0) || (o_coils_first == PAT1) ||
                           (o_coils_first == PAT2) || (o_coils_first == PAT3);
    assign second_is_pat = (o_coils_second == PAT0) || (o_coils_second == PAT1) ||
                           (o_coils_second == PAT2) || (o_coils_second == PAT3);

    `DSCS_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result after reset")

    `DSCS_ASSERT_IMPLY(a_off_coils, i_clk, i_rst_n, o_out_valid && !o_motors_enabled,
        o_coils_first == COILS_OFF && o_coils_second == COILS_OFF, "coils not released while off")

    `DSCS_ASSERT_IMPLY(a_step_first_pat, i_clk, i_rst_n, o_out_valid && o_stepped_first,
        o_motors_enabled && first_is_pat, "motor one stepped without a phase pattern")

    `DSCS_ASSERT_IMPLY(a_step_second_pat, i_clk, i_rst_n, o_out_valid && o_stepped_second,
        o_motors_enabled && second_is_pat, "motor two stepped without a phase pattern")

    `DSCS_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_coils_first) && $stable(o_coils_second), "stalled item changed")

endmodule

bind dual_stepper_command_sequencer dscs_checker u_dscs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_coils_first    (o_coils_first),
    .o_coils_second   (o_coils_second),
    .o_motors_enabled (o_motors_enabled),
    .o_stepped_first  (o_stepped_first),
    .o_stepped_second (o_stepped_second)
);

`default_nettype wire
